// File: rtl/shape_pair_overlap_test_core_macros.svh
// assertion macros used by the shape pair overlap test sequencer
`ifndef SHAPE_PAIR_OVERLAP_TEST_CORE_MACROS_SVH
`define SHAPE_PAIR_OVERLAP_TEST_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/spo_pkg.sv
package spo_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 84;
    localparam int EXT_W  = 60;
    localparam int DL_W   = 44;
    localparam int TMP_W  = 42;
    localparam int PC_W   = 4;

    localparam logic [1:0] KIND_AABB   = 2'd0;
    localparam logic [1:0] KIND_OBB    = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic signed [15:0] AXIS_ONE = 16'sd16384;

    localparam logic [1:0] AXIS_LAST = 2'd3;

    typedef enum logic [2:0] {
        M_NONE,
        M_AABB,
        M_SAT,
        M_BC,
        M_CC
    } t_mode;

    typedef enum logic [5:0] {
        U_NOP,
        U_BPU0, U_BPU1, U_BPV0, U_BPV1, U_BHW, U_BHH,
        U_OPU0, U_OPU1, U_OPV0, U_OPV1, U_OHW, U_OHH,
        U_DXL, U_DYL, U_CMP,
        U_BC0, U_BC1, U_BC2, U_BC3, U_EX, U_EY,
        U_SQX0, U_SQX1, U_SQX2, U_SQY0, U_SQY1, U_SQY2, U_RSQ, U_FIN,
        U_CC0, U_CC1, U_CC2,
        U_AABB
    } t_uop;

    typedef struct packed {
        logic       hold;
        logic       load;
        t_mode      mode;
        t_uop       uop;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic [1:0] held_kind;
        logic       hit;
    } t_stat;

    localparam logic [PC_W-1:0] SAT_LAST  = 4'd14;
    localparam logic [PC_W-1:0] BC_LAST   = 4'd13;
    localparam logic [PC_W-1:0] CC_LAST   = 4'd3;
    localparam logic [PC_W-1:0] AABB_LAST = 4'd0;

    function automatic t_mode f_mode(logic [1:0] hk, logic [1:0] k);
        t_mode m;
        if (hk == KIND_NONE || k == KIND_NONE) begin
            m = M_NONE;
        end else if (hk == KIND_CIRCLE && k == KIND_CIRCLE) begin
            m = M_CC;
        end else if (hk == KIND_CIRCLE || k == KIND_CIRCLE) begin
            m = M_BC;
        end else if (hk == KIND_AABB && k == KIND_AABB) begin
            m = M_AABB;
        end else begin
            m = M_SAT;
        end
        return m;
    endfunction

    function automatic logic f_last(t_mode m, logic [PC_W-1:0] pc);
        logic l;
        unique case (m)
            M_SAT:   l = (pc == SAT_LAST);
            M_BC:    l = (pc == BC_LAST);
            M_CC:    l = (pc == CC_LAST);
            M_AABB:  l = (pc == AABB_LAST);
            default: l = 1'b1;
        endcase
        return l;
    endfunction

    // micro program, one op issued per cycle; its product is registered in r_prod and the op in r_pop, which applies it
    function automatic t_uop f_uop(t_mode m, logic [PC_W-1:0] pc);
        t_uop u;
        u = U_NOP;
        unique case (m)
            M_SAT: begin
                unique case (pc)
                    4'd0:    u = U_BPU0;
                    4'd1:    u = U_BPU1;
                    4'd2:    u = U_BPV0;
                    4'd3:    u = U_BPV1;
                    4'd4:    u = U_BHW;
                    4'd5:    u = U_BHH;
                    4'd6:    u = U_OPU0;
                    4'd7:    u = U_OPU1;
                    4'd8:    u = U_OPV0;
                    4'd9:    u = U_OPV1;
                    4'd10:   u = U_OHW;
                    4'd11:   u = U_OHH;
                    4'd12:   u = U_DXL;
                    4'd13:   u = U_DYL;
                    4'd14:   u = U_CMP;
                    default: u = U_NOP;
                endcase
            end
            M_BC: begin
                unique case (pc)
                    4'd0:    u = U_BC0;
                    4'd1:    u = U_BC1;
                    4'd2:    u = U_BC2;
                    4'd3:    u = U_BC3;
                    4'd4:    u = U_EX;
                    4'd5:    u = U_EY;
                    4'd6:    u = U_SQX0;
                    4'd7:    u = U_SQX1;
                    4'd8:    u = U_SQX2;
                    4'd9:    u = U_SQY0;
                    4'd10:   u = U_SQY1;
                    4'd11:   u = U_SQY2;
                    4'd12:   u = U_RSQ;
                    4'd13:   u = U_FIN;
                    default: u = U_NOP;
                endcase
            end
            M_CC: begin
                unique case (pc)
                    4'd0:    u = U_CC0;
                    4'd1:    u = U_CC1;
                    4'd2:    u = U_CC2;
                    4'd3:    u = U_FIN;
                    default: u = U_NOP;
                endcase
            end
            M_AABB:  u = U_AABB;
            default: u = U_NOP;
        endcase
        return u;
    endfunction

endpackage

// File: rtl/spo_ctrl.sv
`include "shape_pair_overlap_test_core_macros.svh"

module spo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_slot,
    input  logic [1:0]     i_kind,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_overlaps,
    output spo_pkg::t_cmd  o_cmd,
    input  spo_pkg::t_stat i_stat
);
    import spo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_mode           r_mode, n_mode;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [1:0]      r_axis, n_axis;
    logic            r_ovalid, n_ovalid;
    logic            r_oval, n_oval;

    logic  in_acc;
    logic  out_free;
    t_mode new_mode;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign new_mode = f_mode(i_stat.held_kind, i_kind);

    assign o_cmd.hold = in_acc && !i_slot;
    assign o_cmd.load = in_acc && i_slot;
    assign o_cmd.mode = new_mode;
    assign o_cmd.uop  = (r_state == S_RUN) ? f_uop(r_mode, r_pc) : U_NOP;
    assign o_cmd.axis = r_axis;

    assign o_valid    = r_ovalid;
    assign o_overlaps = r_oval;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_pc     = r_pc;
        n_axis   = r_axis;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_slot) begin
                    n_mode  = new_mode;
                    n_pc    = '0;
                    n_axis  = '0;
                    n_state = (new_mode == M_NONE) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (f_last(r_mode, r_pc)) begin
                    if (r_mode == M_SAT && r_axis != AXIS_LAST) begin
                        n_axis = r_axis + 2'd1;
                        n_pc   = '0;
                    end else begin
                        n_state = S_WAIT;
                    end
                end else begin
                    n_pc = r_pc + 4'd1;
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oval   = i_stat.hit;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_NONE;
            r_pc     <= '0;
            r_axis   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_pc     <= n_pc;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval <= n_oval;
    end

    `SPO_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_valid, "finished test did not reach the output register")
    `SPO_ASSERT_NOW(a_run_not_none, i_clk, i_rst_n, r_state == S_RUN, r_mode != M_NONE, "sequencer running with no shape pair")
    `SPO_ASSERT_NOW(a_axis_sat_only, i_clk, i_rst_n, (r_state == S_RUN) && (r_mode != M_SAT), r_axis == 2'd0, "axis counter moved outside the box axis test")
    `SPO_ASSERT_NOW(a_busy_no_cmd, i_clk, i_rst_n, r_state != S_IDLE, !o_cmd.hold && !o_cmd.load, "shape captured while busy")

endmodule

// File: rtl/spo_datapath.sv
module spo_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spo_pkg::t_cmd      i_cmd,
    output spo_pkg::t_stat     o_stat,
    input  logic [1:0]         i_kind,
    input  logic signed [23:0] i_center_x,
    input  logic signed [23:0] i_center_y,
    input  logic [22:0]        i_half_width,
    input  logic [22:0]        i_half_height,
    input  logic signed [15:0] i_axis_cos,
    input  logic signed [15:0] i_axis_sin
);
    import spo_pkg::*;

    // held shape
    logic [1:0]         r_h_kind;
    logic signed [23:0] r_h_cx, r_h_cy;
    logic [22:0]        r_h_hw, r_h_hh;
    logic signed [15:0] r_h_cos, r_h_sin;

    // box role and other role of the pair under test
    logic [22:0]        r_b_hw, r_b_hh, r_o_hw, r_o_hh;
    logic signed [15:0] r_b_ux, r_b_uy, r_o_ux, r_o_uy;
    logic signed [24:0] r_dx, r_dy;

    logic signed [TMP_W-1:0]  r_t, r_t2;
    logic signed [EXT_W-1:0]  r_ext;
    logic signed [DL_W-1:0]   r_dl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    t_uop                     r_pop;
    logic                     r_hit;

    logic               swap;
    logic signed [15:0] h_ux, h_uy, n_ux, n_uy;
    logic signed [16:0] b_ux17, b_uy17, o_ux17, o_uy17, lx, ly;
    logic [TMP_W-1:0]   t_abs, t2_abs;
    logic [DL_W-1:0]    dl_abs;
    logic [24:0]        dx_abs, dy_abs;
    logic [23:0]        r_sum;
    logic [19:0]        t_hi, t2_hi;
    logic [20:0]        t_lo, t2_lo;
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [TMP_W:0]    ex_c, ey_c;

    // axis-aligned box and circle use the unit x axis
    assign h_ux = (r_h_kind == KIND_OBB) ? r_h_cos : AXIS_ONE;
    assign h_uy = (r_h_kind == KIND_OBB) ? r_h_sin : 16'sd0;
    assign n_ux = (i_kind == KIND_OBB) ? i_axis_cos : AXIS_ONE;
    assign n_uy = (i_kind == KIND_OBB) ? i_axis_sin : 16'sd0;
    // box against held circle: the new shape is the box
    assign swap = (r_h_kind == KIND_CIRCLE) && (i_kind != KIND_CIRCLE);

    assign b_ux17 = 17'(r_b_ux);
    assign b_uy17 = 17'(r_b_uy);
    assign o_ux17 = 17'(r_o_ux);
    assign o_uy17 = 17'(r_o_uy);

    always_comb begin
        unique case (i_cmd.axis)
            2'd0: begin
                lx = b_ux17;
                ly = b_uy17;
            end
            2'd1: begin
                lx = -b_uy17;
                ly = b_ux17;
            end
            2'd2: begin
                lx = o_ux17;
                ly = o_uy17;
            end
            default: begin
                lx = -o_uy17;
                ly = o_ux17;
            end
        endcase
    end

    assign t_abs  = r_t[TMP_W-1] ? TMP_W'(-r_t) : TMP_W'(r_t);
    assign t2_abs = r_t2[TMP_W-1] ? TMP_W'(-r_t2) : TMP_W'(r_t2);
    assign dl_abs = r_dl[DL_W-1] ? DL_W'(-r_dl) : DL_W'(r_dl);
    assign dx_abs = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign dy_abs = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign r_sum  = 24'(r_b_hw) + 24'(r_o_hw);

    // clamped excess split into a high part (bits 40:21) and a low part (bits 20:0) for squaring
    assign t_hi  = r_t[40:21];
    assign t_lo  = r_t[20:0];
    assign t2_hi = r_t2[40:21];
    assign t2_lo = r_t2[20:0];

    assign ex_c = $signed({1'b0, t_abs}) - $signed((TMP_W+1)'({r_b_hw, 14'd0}));
    assign ey_c = $signed({1'b0, t2_abs}) - $signed((TMP_W+1)'({r_b_hh, 14'd0}));

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.uop)
            U_BPU0: begin op_a = MUL_W'(b_ux17);  op_b = MUL_W'(lx); end
            U_BPU1: begin op_a = MUL_W'(b_uy17);  op_b = MUL_W'(ly); end
            U_BPV0: begin op_a = -MUL_W'(b_uy17); op_b = MUL_W'(lx); end
            U_BPV1: begin op_a = MUL_W'(b_ux17);  op_b = MUL_W'(ly); end
            U_BHW: begin
                op_a = $signed(MUL_W'(r_b_hw));
                op_b = $signed(MUL_W'(t_abs[31:0]));
            end
            U_BHH: begin
                op_a = $signed(MUL_W'(r_b_hh));
                op_b = $signed(MUL_W'(t2_abs[31:0]));
            end
            U_OPU0: begin op_a = MUL_W'(o_ux17);  op_b = MUL_W'(lx); end
            U_OPU1: begin op_a = MUL_W'(o_uy17);  op_b = MUL_W'(ly); end
            U_OPV0: begin op_a = -MUL_W'(o_uy17); op_b = MUL_W'(lx); end
            U_OPV1: begin op_a = MUL_W'(o_ux17);  op_b = MUL_W'(ly); end
            U_OHW: begin
                op_a = $signed(MUL_W'(r_o_hw));
                op_b = $signed(MUL_W'(t_abs[31:0]));
            end
            U_OHH: begin
                op_a = $signed(MUL_W'(r_o_hh));
                op_b = $signed(MUL_W'(t2_abs[31:0]));
            end
            U_DXL: begin op_a = MUL_W'(r_dx); op_b = MUL_W'(lx); end
            U_DYL: begin op_a = MUL_W'(r_dy); op_b = MUL_W'(ly); end
            U_BC0: begin op_a = MUL_W'(r_dx); op_b = MUL_W'(b_ux17); end
            U_BC1: begin op_a = MUL_W'(r_dy); op_b = MUL_W'(b_uy17); end
            U_BC2: begin op_a = MUL_W'(r_dx); op_b = -MUL_W'(b_uy17); end
            U_BC3: begin op_a = MUL_W'(r_dy); op_b = MUL_W'(b_ux17); end
            U_SQX0: begin op_a = $signed(MUL_W'(t_hi)); op_b = $signed(MUL_W'(t_hi)); end
            U_SQX1: begin op_a = $signed(MUL_W'(t_hi)); op_b = $signed(MUL_W'(t_lo)); end
            U_SQX2: begin op_a = $signed(MUL_W'(t_lo)); op_b = $signed(MUL_W'(t_lo)); end
            U_SQY0: begin op_a = $signed(MUL_W'(t2_hi)); op_b = $signed(MUL_W'(t2_hi)); end
            U_SQY1: begin op_a = $signed(MUL_W'(t2_hi)); op_b = $signed(MUL_W'(t2_lo)); end
            U_SQY2: begin op_a = $signed(MUL_W'(t2_lo)); op_b = $signed(MUL_W'(t2_lo)); end
            U_RSQ: begin
                op_a = $signed(MUL_W'(r_o_hw));
                op_b = $signed(MUL_W'(r_o_hw));
            end
            U_CC0: begin op_a = $signed(MUL_W'(dx_abs)); op_b = $signed(MUL_W'(dx_abs)); end
            U_CC1: begin op_a = $signed(MUL_W'(dy_abs)); op_b = $signed(MUL_W'(dy_abs)); end
            U_CC2: begin op_a = $signed(MUL_W'(r_sum));  op_b = $signed(MUL_W'(r_sum)); end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_c = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_kind <= KIND_NONE;
            r_h_cx   <= '0;
            r_h_cy   <= '0;
            r_h_hw   <= '0;
            r_h_hh   <= '0;
            r_h_cos  <= AXIS_ONE;
            r_h_sin  <= '0;
            r_pop    <= U_NOP;
        end else begin
            r_pop <= i_cmd.uop;
            if (i_cmd.hold) begin
                r_h_kind <= i_kind;
                r_h_cx   <= i_center_x;
                r_h_cy   <= i_center_y;
                r_h_hw   <= i_half_width;
                r_h_hh   <= i_half_height;
                r_h_cos  <= i_axis_cos;
                r_h_sin  <= i_axis_sin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        if (i_cmd.load) begin
            r_dx  <= 25'(i_center_x) - 25'(r_h_cx);
            r_dy  <= 25'(i_center_y) - 25'(r_h_cy);
            r_hit <= (i_cmd.mode == M_SAT);
            if (swap) begin
                r_b_hw <= i_half_width;
                r_b_hh <= i_half_height;
                r_b_ux <= n_ux;
                r_b_uy <= n_uy;
                r_o_hw <= r_h_hw;
                r_o_hh <= r_h_hh;
                r_o_ux <= h_ux;
                r_o_uy <= h_uy;
            end else begin
                r_b_hw <= r_h_hw;
                r_b_hh <= r_h_hh;
                r_b_ux <= h_ux;
                r_b_uy <= h_uy;
                r_o_hw <= i_half_width;
                r_o_hh <= i_half_height;
                r_o_ux <= n_ux;
                r_o_uy <= n_uy;
            end
        end
        unique case (r_pop)
            U_BPU0, U_OPU0, U_BC0: r_t  <= TMP_W'(r_prod);
            U_BPU1, U_OPU1, U_BC1: r_t  <= r_t + TMP_W'(r_prod);
            U_BPV0, U_OPV0, U_BC2: r_t2 <= TMP_W'(r_prod);
            U_BPV1, U_OPV1, U_BC3: r_t2 <= r_t2 + TMP_W'(r_prod);
            U_BHW:                 r_ext <= EXT_W'(r_prod);
            U_BHH, U_OHW, U_OHH:   r_ext <= r_ext + EXT_W'(r_prod);
            U_DXL:                 r_dl <= DL_W'(r_prod);
            U_DYL:                 r_dl <= r_dl + DL_W'(r_prod);
            U_CMP: begin
                if (EXT_W'({dl_abs, 14'd0}) > $unsigned(r_ext)) begin
                    r_hit <= 1'b0;
                end
            end
            U_EX:   r_t  <= ex_c[TMP_W] ? '0 : ex_c[TMP_W-1:0];
            U_EY:   r_t2 <= ey_c[TMP_W] ? '0 : ey_c[TMP_W-1:0];
            U_SQX0: r_acc <= ACC_W'(r_prod) << 42;
            U_SQX1, U_SQY1: r_acc <= r_acc + (ACC_W'(r_prod) << 22);
            U_SQX2, U_SQY2: r_acc <= r_acc + ACC_W'(r_prod);
            U_SQY0: r_acc <= r_acc + (ACC_W'(r_prod) << 42);
            U_RSQ:  r_acc <= r_acc - (ACC_W'(r_prod) << 28);
            U_CC0:  r_acc <= ACC_W'(r_prod);
            U_CC1:  r_acc <= r_acc + ACC_W'(r_prod);
            U_CC2:  r_acc <= r_acc - ACC_W'(r_prod);
            U_FIN:  r_hit <= r_acc[ACC_W-1] || (r_acc == '0);
            U_AABB: begin
                r_hit <= ({1'b0, dx_abs} < 26'(r_b_hw) + 26'(r_o_hw)) &&
                         ({1'b0, dy_abs} < 26'(r_b_hh) + 26'(r_o_hh));
            end
            default: begin
            end
        endcase
    end

    assign o_stat.held_kind = r_h_kind;
    assign o_stat.hit       = r_hit;

endmodule

// File: rtl/shape_pair_overlap_test_core.sv
// channel   valid     ready     payload
// input     i_valid   o_ready   i_slot i_kind i_center_x/y i_half_width/height i_axis_cos/sin
// output    o_valid   i_ready   o_overlaps
//
// a slot 0 word only updates the held shape, and o_ready stays high after it
// a slot 1 word runs a micro program on one shared 33x33 multiplier, one op per cycle:
//   rotated box pair 60 ops (four axes of 15), box against circle 14, circle pair 4,
//   axis-aligned pair 1, kind none 0; after the last op the sequencer passes S_WAIT and S_DONE,
//   and the result enters the output register from S_DONE once that register is free
// reset (i_rst_n low, synchronous) clears the sequencer and sets the held shape to none
// the output register holds one word; o_ready stays low from a test word until its
//   result is in that register, and stays low longer while that register is still full
module shape_pair_overlap_test_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_slot,
    input  logic [1:0]         i_kind,
    input  logic signed [23:0] i_center_x,
    input  logic signed [23:0] i_center_y,
    input  logic [22:0]        i_half_width,
    input  logic [22:0]        i_half_height,
    input  logic signed [15:0] i_axis_cos,
    input  logic signed [15:0] i_axis_sin,
    // result words
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_overlaps
);
    import spo_pkg::*;

    // command from the sequencer, status back from the arithmetic
    t_cmd  cmd;
    t_stat stat;

    // sequencer: handshakes, program counter, axis loop, output register
    spo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_slot     (i_slot),
        .i_kind     (i_kind),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_overlaps (o_overlaps),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // held shape, pair registers, shared multiplier and accumulators
    spo_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_half_width  (i_half_width),
        .i_half_height (i_half_height),
        .i_axis_cos    (i_axis_cos),
        .i_axis_sin    (i_axis_sin)
    );

endmodule
